// File: sv/inner_loop_power_control_top_assert.svh
// ----------------------------------------------------------------------------
// Inner loop power control: assertion macros
// Shorthand for clocked, reset-qualified concurrent checks. The enclosing
// module must have i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef INNER_LOOP_POWER_CONTROL_TOP_ASSERT_SVH
`define INNER_LOOP_POWER_CONTROL_TOP_ASSERT_SVH

// Same-cycle implication
`define ILPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ILPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ilpc_pkg.sv
// ----------------------------------------------------------------------------
// Inner loop power control package
// Transaction types, register map, request and status codes, and the
// control interface between sequencer and datapath.
// ----------------------------------------------------------------------------
package ilpc_pkg;

    // Register map
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_TIMING_MODE        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SINR_THRESHOLD     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_UP            = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_DOWN          = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_POWER          = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_POWER          = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_DESPREAD_SCALE     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERFERENCE_SCALE = 3'd7;

    // Register reset values
    localparam logic [1:0]  RST_TIMING_MODE        = 2'd0;
    localparam logic [31:0] RST_SINR_THRESHOLD     = 32'd65536;
    localparam logic [15:0] RST_STEP_UP            = 16'd5157;
    localparam logic [15:0] RST_STEP_DOWN          = 16'd52057;
    localparam logic [31:0] RST_MAX_POWER          = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_MIN_POWER          = 32'd0;
    localparam logic [15:0] RST_DESPREAD_SCALE     = 16'd32768;
    localparam logic [15:0] RST_INTERFERENCE_SCALE = 16'd32768;

    // Timing mode bits
    localparam int TM_CMD_AT_START   = 0;
    localparam int TM_APPLY_AT_START = 1;

    // Request types
    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_RX_START = 2'd1;
    localparam logic [1:0] REQ_RX_END   = 2'd2;
    localparam logic [1:0] REQ_TX_QUERY = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNKNOWN = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] link_id;
        logic [31:0] rx_power;
        logic [31:0] noise_power;
        logic [31:0] interference_power;
        logic [9:0]  spread_factor;
        logic        power_up_cmd;
    } t_in_item;

    typedef struct packed {
        logic [31:0] tx_power;
        logic        power_up_flag;
        logic [1:0]  status;
    } t_out_item;

    // One link table entry
    typedef struct packed {
        logic [15:0] link;
        logic [31:0] power;
        logic        up;
        logic [31:0] intf;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_DEN,
        S_MUL,
        S_CMP,
        S_PMUL,
        S_PUPD,
        S_DONE
    } t_state;

    // Sequencer to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic new_entry;
        logic set_unknown;
        logic set_full;
        logic den;
        logic mul;
        logic cmp;
        logic pmul;
        logic pupd;
        logic finish;
    } t_dp_cmd;

    // Datapath to sequencer
    typedef struct packed {
        logic scan_done;
        logic hit;
        logic free_found;
        logic is_register;
        logic is_rx;
        logic do_cmp;
        logic do_apply;
        logic out_busy;
    } t_dp_sts;

endpackage

// File: sv/ilpc_ctrl.sv
// ----------------------------------------------------------------------------
// Inner loop power control sequencer
// Steps one transaction through table scan, decision, SINR compare, power
// step and write-back, and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "inner_loop_power_control_top_assert.svh"

module ilpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ilpc_pkg::t_dp_sts i_sts,
    output ilpc_pkg::t_dp_cmd o_cmd
);
    import ilpc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic [10:0] w_cmd_bits;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.hit && i_sts.is_rx && i_sts.do_cmp) begin
                    n_state = S_DEN;
                end else if (i_sts.hit && i_sts.is_rx && i_sts.do_apply) begin
                    n_state = S_PMUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DEN:  n_state = S_MUL;
            S_MUL:  n_state = S_CMP;
            S_CMP: begin
                n_state = i_sts.do_apply ? S_PMUL : S_DONE;
            end
            S_PMUL: n_state = S_PUPD;
            S_PUPD: n_state = S_DONE;
            S_DONE: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: o_cmd.load = i_in_valid;
            S_SCAN: o_cmd.scan = 1'b1;
            S_DECIDE: begin
                if (!i_sts.hit) begin
                    if (i_sts.is_register) begin
                        if (i_sts.free_found) begin
                            o_cmd.new_entry = 1'b1;
                        end else begin
                            o_cmd.set_full = 1'b1;
                        end
                    end else begin
                        o_cmd.set_unknown = 1'b1;
                    end
                end
            end
            S_DEN:  o_cmd.den  = 1'b1;
            S_MUL:  o_cmd.mul  = 1'b1;
            S_CMP:  o_cmd.cmp  = 1'b1;
            S_PMUL: o_cmd.pmul = 1'b1;
            S_PUPD: o_cmd.pupd = 1'b1;
            S_DONE: o_cmd.finish = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

    // Hold off new transactions until the current one is handed over
    assign o_in_stall = (r_state != S_IDLE);

    assign w_cmd_bits = o_cmd;

    `ILPC_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(w_cmd_bits), "ilpc_ctrl: overlapping commands")
    `ILPC_ASSERT_NXT(a_accept_scan, i_in_valid && !o_in_stall, r_state == S_SCAN, "ilpc_ctrl: accept did not start scan")
    `ILPC_ASSERT_NXT(a_scan_exit, r_state == S_SCAN && i_sts.scan_done, r_state == S_DECIDE, "ilpc_ctrl: scan did not end")

endmodule

// File: sv/ilpc_dp.sv
// ----------------------------------------------------------------------------
// Inner loop power control datapath
// Holds the registers, the link table memory and its valid bits, the
// despread and interference products, the SINR compare, the power step
// and the output register.
// ----------------------------------------------------------------------------
`include "inner_loop_power_control_top_assert.svh"

module ilpc_dp #(
    parameter int NUM_LINKS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ilpc_pkg::t_dp_cmd                   i_cmd,
    output ilpc_pkg::t_dp_sts                   o_sts,
    input  ilpc_pkg::t_in_item                  i_in_data,
    input  logic                                i_cfg_we,
    input  logic [ilpc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [ilpc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output ilpc_pkg::t_out_item                 o_out_data
);
    import ilpc_pkg::*;

    localparam int IW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
    localparam int PW = $clog2(NUM_LINKS + 1);

    // Configuration
    logic [1:0]  r_tm;
    logic [31:0] r_thr;
    logic [15:0] r_step_up;
    logic [15:0] r_step_dn;
    logic [31:0] r_max;
    logic [31:0] r_min;
    logic [15:0] r_dscale;
    logic [15:0] r_iscale;

    // Transaction and table
    t_in_item    r_in;
    t_entry      r_mem [NUM_LINKS];
    logic        r_slot_valid [NUM_LINKS];
    t_entry      r_rd_word;
    logic [PW-1:0] r_ptr;
    logic        r_cmp_v;
    logic        r_cmp_live;
    logic [IW-1:0] r_cmp_idx;
    logic        r_hit;
    logic        r_free_v;
    logic [IW-1:0] r_free_idx;
    logic        r_new;
    logic [IW-1:0] r_slot;
    logic [31:0] r_power;
    logic        r_up;
    logic [31:0] r_intf;
    logic [1:0]  r_status;

    // Arithmetic
    logic [41:0] r_m1;
    logic [42:0] r_desp;
    logic [31:0] r_si;
    logic [32:0] r_den;
    logic [63:0] r_prod;
    logic [47:0] r_pprod;

    // Output register
    logic        r_out_v;
    t_out_item   r_out;

    logic [IW-1:0] w_idx;
    logic        w_issue;
    logic        w_hit_now;
    logic        w_is_start;
    logic        w_is_rx;
    logic        w_write;
    logic        w_out_take;
    logic [47:0] w_iprod;
    logic [32:0] w_ishift;
    logic [57:0] w_dprod;
    logic [31:0] w_den_i;
    logic [64:0] w_right;
    logic [64:0] w_left;
    logic [15:0] w_step;
    logic [35:0] w_np_up;
    logic [31:0] w_np_dn;
    t_entry      w_wr_word;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tm      <= RST_TIMING_MODE;
            r_thr     <= RST_SINR_THRESHOLD;
            r_step_up <= RST_STEP_UP;
            r_step_dn <= RST_STEP_DOWN;
            r_max     <= RST_MAX_POWER;
            r_min     <= RST_MIN_POWER;
            r_dscale  <= RST_DESPREAD_SCALE;
            r_iscale  <= RST_INTERFERENCE_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TIMING_MODE:        r_tm      <= i_cfg_wdata[1:0];
                CFG_SINR_THRESHOLD:     r_thr     <= i_cfg_wdata[31:0];
                CFG_STEP_UP:            r_step_up <= i_cfg_wdata[15:0];
                CFG_STEP_DOWN:          r_step_dn <= i_cfg_wdata[15:0];
                CFG_MAX_POWER:          r_max     <= i_cfg_wdata[31:0];
                CFG_MIN_POWER:          r_min     <= i_cfg_wdata[31:0];
                CFG_DESPREAD_SCALE:     r_dscale  <= i_cfg_wdata[15:0];
                CFG_INTERFERENCE_SCALE: r_iscale  <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Request decode
    assign w_is_start = (r_in.req_type == REQ_RX_START);
    assign w_is_rx    = w_is_start || (r_in.req_type == REQ_RX_END);

    // Scan addressing and match on the registered read word
    assign w_idx     = r_ptr[IW-1:0];
    assign w_issue   = (r_ptr < PW'(NUM_LINKS));
    assign w_hit_now = r_cmp_v && r_cmp_live && (r_rd_word.link == r_in.link_id);

    // Entry written back at the end of a transaction
    assign w_write = i_cmd.finish && (r_new || (r_hit && w_is_rx));
    always_comb begin
        w_wr_word.link  = r_in.link_id;
        w_wr_word.power = r_power;
        w_wr_word.up    = r_up;
        w_wr_word.intf  = (r_in.req_type == REQ_RX_END) ? r_si : r_intf;
    end

    // Link table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && w_issue) begin
            r_rd_word <= r_mem[w_idx];
        end
        if (w_write) begin
            r_mem[r_slot] <= w_wr_word;
        end
    end

    // Slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LINKS; i++) begin
                r_slot_valid[i] <= 1'b0;
            end
        end else if (i_cmd.finish && r_new) begin
            r_slot_valid[r_slot] <= 1'b1;
        end
    end

    // Scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_cmp_v  <= 1'b0;
            r_hit    <= 1'b0;
            r_free_v <= 1'b0;
            r_new    <= 1'b0;
        end else if (i_cmd.load) begin
            r_ptr    <= '0;
            r_cmp_v  <= 1'b0;
            r_hit    <= 1'b0;
            r_free_v <= 1'b0;
            r_new    <= 1'b0;
        end else begin
            if (i_cmd.scan) begin
                r_cmp_v <= w_issue;
                if (w_issue) begin
                    r_ptr <= r_ptr + PW'(1);
                    if (!r_slot_valid[w_idx] && !r_free_v) begin
                        r_free_v <= 1'b1;
                    end
                end
                if (w_hit_now) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.new_entry) begin
                r_new <= 1'b1;
            end else if (i_cmd.finish) begin
                r_new <= 1'b0;
            end
        end
    end

    // Scan payload: compare stage, first free slot, captured entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= w_idx;
            if (w_issue) begin
                r_cmp_live <= r_slot_valid[w_idx];
                if (!r_slot_valid[w_idx] && !r_free_v) begin
                    r_free_idx <= w_idx;
                end
            end else begin
                r_cmp_live <= 1'b0;
            end
            if (w_hit_now) begin
                r_slot  <= r_cmp_idx;
                r_power <= r_rd_word.power;
                r_up    <= r_rd_word.up;
                r_intf  <= r_rd_word.intf;
            end
        end
        if (i_cmd.new_entry) begin
            r_slot  <= r_free_idx;
            r_power <= r_max;
            r_up    <= 1'b1;
            r_intf  <= '0;
        end
        if (i_cmd.cmp) begin
            r_up <= (w_left < w_right);
        end
        if (i_cmd.pupd) begin
            if (r_in.power_up_cmd) begin
                if (w_np_up < {4'd0, r_max}) r_power <= w_np_up[31:0];
            end else begin
                if (w_np_dn > r_min) r_power <= w_np_dn;
            end
        end
        if (i_cmd.load) begin
            r_status <= ST_OK;
        end else if (i_cmd.set_unknown) begin
            r_status <= ST_UNKNOWN;
        end else if (i_cmd.set_full) begin
            r_status <= ST_FULL;
        end
    end

    // Despread power and scaled interference, settle during the scan
    assign w_iprod  = {16'd0, r_in.interference_power} * {32'd0, r_iscale};
    assign w_ishift = w_iprod[47:15];
    assign w_dprod  = {16'd0, r_m1} * {42'd0, r_dscale};
    always_ff @(posedge i_clk) begin
        r_m1   <= {32'd0, r_in.spread_factor} * {10'd0, r_in.rx_power};
        r_desp <= w_dprod[57:15];
        r_si   <= w_ishift[32] ? 32'hFFFF_FFFF : w_ishift[31:0];
    end

    // SINR compare: despread * 2^16 < threshold * (noise + interference)
    assign w_den_i = w_is_start ? r_intf : r_si;
    assign w_right = {1'b0, r_prod} + (r_den[32] ? {1'b0, r_thr, 32'd0} : 65'd0);
    assign w_left  = {6'd0, r_desp, 16'd0};

    // Power step products
    assign w_step  = r_in.power_up_cmd ? r_step_up : r_step_dn;
    assign w_np_up = r_pprod[47:12];
    assign w_np_dn = r_pprod[47:16];

    always_ff @(posedge i_clk) begin
        if (i_cmd.den) begin
            r_den <= {1'b0, r_in.noise_power} + {1'b0, w_den_i};
        end
        if (i_cmd.mul) begin
            r_prod <= {32'd0, r_thr} * {32'd0, r_den[31:0]};
        end
        if (i_cmd.pmul) begin
            r_pprod <= {16'd0, r_power} * {32'd0, w_step};
        end
    end

    // Output register
    assign w_out_take = r_out_v && !i_out_stall;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_v <= 1'b1;
        end else if (w_out_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.status        <= r_status;
            r_out.tx_power      <= (r_status == ST_OK) ? r_power : 32'd0;
            r_out.power_up_flag <= (r_status == ST_OK) ? r_up : 1'b0;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // Status to the sequencer
    always_comb begin
        o_sts.scan_done   = w_hit_now || (r_cmp_v && (r_cmp_idx == IW'(NUM_LINKS - 1)));
        o_sts.hit         = r_hit;
        o_sts.free_found  = r_free_v;
        o_sts.is_register = (r_in.req_type == REQ_REGISTER);
        o_sts.is_rx       = w_is_rx;
        o_sts.do_cmp      = w_is_start ? r_tm[TM_CMD_AT_START] : !r_tm[TM_CMD_AT_START];
        o_sts.do_apply    = w_is_start ? r_tm[TM_APPLY_AT_START] : !r_tm[TM_APPLY_AT_START];
        o_sts.out_busy    = r_out_v && i_out_stall;
    end

    `ILPC_ASSERT_IMP(a_hit_slot_valid, r_hit, r_slot_valid[r_slot], "ilpc_dp: hit on invalid slot")
    `ILPC_ASSERT_IMP(a_new_slot_free, r_new, !r_slot_valid[r_slot], "ilpc_dp: new link on used slot")
    `ILPC_ASSERT_IMP(a_finish_room, i_cmd.finish, !(r_out_v && i_out_stall), "ilpc_dp: result overwritten")

endmodule

// File: sv/inner_loop_power_control_top.sv
// ----------------------------------------------------------------------------
// Inner loop power control, top level
// Closed-loop transmit power control over a table of peer links.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one request:
//   register link, rx start, rx end or tx query. Output channel (o_out_valid
//   / i_out_stall / o_out_data) returns exactly one result per request.
//   Registers are written through i_cfg_we / i_cfg_addr / i_cfg_wdata while
//   no request is in flight.
//   The link table is scanned one slot per cycle through its single read
//   port. A hit ends the scan early. A tx query or a known registration
//   then goes straight to the result; an rx event may add the SINR
//   compare, the power step or both, as the timing mode selects. A miss
//   or a new registration scans all slots. The next request is accepted
//   the cycle after the result is loaded into the output register.
//   A stalled result stays in the output register while the next request
//   is accepted and worked on; that request waits at its end until the
//   register frees up.
//   Reset empties the table and restores the register defaults.
// ----------------------------------------------------------------------------
module inner_loop_power_control_top #(
    parameter int NUM_LINKS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ilpc_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ilpc_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [ilpc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ilpc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ilpc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer
    ilpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath
    ilpc_dp #(
        .NUM_LINKS (NUM_LINKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
